>>> rtl/core/msqrt_pkg.sv
// shared types and constants of the modular square root block
// no dependencies
package msqrt_pkg;

    localparam int WIDTH_DEF    = 32;
    localparam int FIELD_W      = 32;
    localparam int NONRES_LIMIT = 1024;
    localparam int NR_W         = 11;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NOSQ = 1'b1;

    typedef enum logic [24:0] {
        S_IDLE   = 25'b1 << 0,
        S_RWAIT  = 25'b1 << 1,
        S_FACT   = 25'b1 << 2,
        S_POW    = 25'b1 << 3,
        S_PACC   = 25'b1 << 4,
        S_PSQ    = 25'b1 << 5,
        S_MWAIT  = 25'b1 << 6,
        S_EULER  = 25'b1 << 7,
        S_ROOT3  = 25'b1 << 8,
        S_SEARCH = 25'b1 << 9,
        S_NRCHK  = 25'b1 << 10,
        S_GOTZ   = 25'b1 << 11,
        S_GOTR   = 25'b1 << 12,
        S_GOTT   = 25'b1 << 13,
        S_LOOP   = 25'b1 << 14,
        S_FIND   = 25'b1 << 15,
        S_FINDW  = 25'b1 << 16,
        S_BSQ    = 25'b1 << 17,
        S_BSQW   = 25'b1 << 18,
        S_UPR    = 25'b1 << 19,
        S_UPZ    = 25'b1 << 20,
        S_UPT    = 25'b1 << 21,
        S_VERIFY = 25'b1 << 22,
        S_CHECK  = 25'b1 << 23,
        S_DONE   = 25'b1 << 24
    } t_state;

endpackage

>>> rtl/core/msqrt_if.sv
// valid/ready channel interfaces for items in and results out
// depends on msqrt_pkg for field widths
interface msqrt_in_if;
    logic                            valid;
    logic                            ready;
    logic [msqrt_pkg::FIELD_W-1:0]   prime;
    logic [msqrt_pkg::FIELD_W-1:0]   residue;
    modport source (output valid, output prime, output residue, input ready);
    modport sink   (input valid, input prime, input residue, output ready);
endinterface

interface msqrt_out_if;
    logic                            valid;
    logic                            ready;
    logic [msqrt_pkg::FIELD_W-1:0]   root_low;
    logic [msqrt_pkg::FIELD_W-1:0]   root_high;
    logic                            status;
    modport source (output valid, output root_low, output root_high, output status,
                    input ready);
    modport sink   (input valid, input root_low, input root_high, input status,
                    output ready);
endinterface

>>> rtl/core/msqrt_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
// operands must be below the modulus; no package dependency
module msqrt_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_acc, n_acc, r_x, n_x, r_y, n_y;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;

    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[WIDTH-1:0];
    endfunction

    always_comb begin
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_x   = i_x;
            n_y   = i_y;
            n_cnt = CNT_W'(WIDTH);
        end else if (r_cnt != '0) begin
            if (r_y[0]) begin
                n_acc = add_mod(r_acc, r_x, i_m);
            end
            n_x    = add_mod(r_x, r_x, i_m);
            n_y    = r_y >> 1;
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> rtl/core/msqrt_reduce.sv
// restoring remainder unit, one dividend bit per cycle
// no package dependency
module msqrt_reduce #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_rem
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem, r_val, n_val;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [WIDTH:0]   shifted;

    always_comb begin
        n_rem   = r_rem;
        n_val   = r_val;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        shifted = {r_rem, r_val[WIDTH-1]};
        if (i_start) begin
            n_rem = '0;
            n_val = i_value;
            n_cnt = CNT_W'(WIDTH);
        end else if (r_cnt != '0) begin
            if (shifted >= {1'b0, i_m}) begin
                shifted = shifted - {1'b0, i_m};
            end
            n_rem  = shifted[WIDTH-1:0];
            n_val  = r_val << 1;
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_val <= n_val;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

>>> rtl/core/modular_square_root.sv
// top level: tonelli-shanks modular square root sequencer
// depends on msqrt_pkg, msqrt_if, msqrt_mulmod, msqrt_reduce
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    prime, residue
//  o_out     out  valid/ready    root_low, root_high, status
//
// one item at a time; ready is high only while the sequencer is idle
// every modular product passes the launching state, the unit's load step, WIDTH
//   multiplier steps and its done flag; an exponent of e bits takes one product per
//   zero bit and two per one bit
// p = 3 mod 4 runs two exponentiations and a check product; other primes run the
//   euler exponentiation, one exponentiation per non-residue candidate, three more
//   for z, r and t, then the reduction loop and the check product
// synchronous active-low reset clears the sequencer and the output valid
// a stalled output holds its item; the next item may be accepted meanwhile and
//   its result waits in the done state until the output register frees
module modular_square_root #(
    parameter int WIDTH = msqrt_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msqrt_in_if.sink    i_in,
    msqrt_out_if.source o_out
);
    localparam int SW = $clog2(WIDTH);
    localparam int NW = msqrt_pkg::NR_W;
    localparam int CW = (WIDTH > NW) ? WIDTH : NW;
    localparam int FW = msqrt_pkg::FIELD_W;

    msqrt_pkg::t_state r_state, n_state, r_ret, n_ret, r_pret, n_pret;

    // working values of the current item
    logic [WIDTH-1:0] r_p, n_p, r_a, n_a, r_q, n_q;
    logic [WIDTH-1:0] r_r, n_r, r_t, n_t, r_z, n_z, r_b, n_b, r_sq, n_sq;
    logic [SW-1:0]    r_s, n_s, r_found, n_found, r_k, n_k;
    logic [NW-1:0]    r_i, n_i;
    // exponentiation registers
    logic [WIDTH-1:0] r_pacc, n_pacc, r_pbase, n_pbase, r_pexp, n_pexp;
    // unit launch
    logic             r_mstart, n_mstart, r_rstart, n_rstart;
    logic [WIDTH-1:0] r_mx, n_mx, r_my, n_my;
    // staged result and output register
    logic [WIDTH-1:0] r_low, n_low, r_high, n_high;
    logic             r_fail, n_fail;
    logic             r_ovalid, n_ovalid;
    logic [FW-1:0]    r_olow, n_olow, r_ohigh, n_ohigh;
    logic             r_ostat, n_ostat;

    logic             mul_done, red_done;
    logic [WIDTH-1:0] mul_prod, red_rem, in_p, in_a;
    logic [SW:0]      bsq_need;

    msqrt_mulmod #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_p),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    msqrt_reduce #(.WIDTH(WIDTH)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rstart),
        .i_value (r_a),
        .i_m     (r_p),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    assign in_p     = WIDTH'(64'(i_in.prime));
    assign in_a     = WIDTH'(64'(i_in.residue));
    assign bsq_need = (SW+1)'(r_k) + (SW+1)'(r_found) + (SW+1)'(1);

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_pret   = r_pret;
        n_p      = r_p;
        n_a      = r_a;
        n_q      = r_q;
        n_r      = r_r;
        n_t      = r_t;
        n_z      = r_z;
        n_b      = r_b;
        n_sq     = r_sq;
        n_s      = r_s;
        n_found  = r_found;
        n_k      = r_k;
        n_i      = r_i;
        n_pacc   = r_pacc;
        n_pbase  = r_pbase;
        n_pexp   = r_pexp;
        n_mstart = 1'b0;
        n_rstart = 1'b0;
        n_mx     = r_mx;
        n_my     = r_my;
        n_low    = r_low;
        n_high   = r_high;
        n_fail   = r_fail;
        n_ovalid = r_ovalid;
        n_olow   = r_olow;
        n_ohigh  = r_ohigh;
        n_ostat  = r_ostat;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            msqrt_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_p = in_p;
                    n_a = in_a;
                    if (in_p < WIDTH'(2)) begin
                        // modulus below two: not a square
                        n_low   = '0;
                        n_high  = '0;
                        n_fail  = msqrt_pkg::STATUS_NOSQ;
                        n_state = msqrt_pkg::S_DONE;
                    end else begin
                        n_rstart = 1'b1;
                        n_state  = msqrt_pkg::S_RWAIT;
                    end
                end
            end
            msqrt_pkg::S_RWAIT: begin
                if (red_done) begin
                    n_a     = red_rem;
                    n_low   = '0;
                    n_high  = '0;
                    n_fail  = msqrt_pkg::STATUS_OK;
                    n_state = msqrt_pkg::S_DONE;
                    if (r_p == WIDTH'(2)) begin
                        n_low  = red_rem;
                        n_high = red_rem;
                    end else if (red_rem == '0) begin
                        // zero residue: root zero
                    end else if (!r_p[0]) begin
                        n_fail = msqrt_pkg::STATUS_NOSQ;
                    end else begin
                        n_q     = r_p - 1'b1;
                        n_s     = '0;
                        n_state = msqrt_pkg::S_FACT;
                    end
                end
            end
            msqrt_pkg::S_FACT: begin
                // strip factors of two from p-1, one per cycle
                if (!r_q[0]) begin
                    n_q = r_q >> 1;
                    n_s = r_s + 1'b1;
                end else begin
                    n_pacc  = WIDTH'(1);
                    n_pbase = r_a;
                    n_pexp  = (r_p - 1'b1) >> 1;
                    n_pret  = msqrt_pkg::S_EULER;
                    n_state = msqrt_pkg::S_POW;
                end
            end
            msqrt_pkg::S_POW: begin
                // right-to-left square and multiply
                if (r_pexp == '0) begin
                    n_state = r_pret;
                end else begin
                    n_mstart = 1'b1;
                    n_state  = msqrt_pkg::S_MWAIT;
                    if (r_pexp[0]) begin
                        n_mx  = r_pacc;
                        n_my  = r_pbase;
                        n_ret = msqrt_pkg::S_PACC;
                    end else begin
                        n_mx  = r_pbase;
                        n_my  = r_pbase;
                        n_ret = msqrt_pkg::S_PSQ;
                    end
                end
            end
            msqrt_pkg::S_PACC: begin
                n_pacc   = mul_prod;
                n_mx     = r_pbase;
                n_my     = r_pbase;
                n_mstart = 1'b1;
                n_ret    = msqrt_pkg::S_PSQ;
                n_state  = msqrt_pkg::S_MWAIT;
            end
            msqrt_pkg::S_PSQ: begin
                n_pbase = mul_prod;
                n_pexp  = r_pexp >> 1;
                n_state = msqrt_pkg::S_POW;
            end
            msqrt_pkg::S_MWAIT: begin
                if (mul_done) begin
                    n_state = r_ret;
                end
            end
            msqrt_pkg::S_EULER: begin
                if (r_pacc != WIDTH'(1)) begin
                    n_fail  = msqrt_pkg::STATUS_NOSQ;
                    n_low   = '0;
                    n_high  = '0;
                    n_state = msqrt_pkg::S_DONE;
                end else if (r_s == SW'(1)) begin
                    n_pacc  = WIDTH'(1);
                    n_pbase = r_a;
                    n_pexp  = (r_p >> 2) + 1'b1;
                    n_pret  = msqrt_pkg::S_ROOT3;
                    n_state = msqrt_pkg::S_POW;
                end else begin
                    n_i     = NW'(2);
                    n_state = msqrt_pkg::S_SEARCH;
                end
            end
            msqrt_pkg::S_ROOT3: begin
                n_r     = r_pacc;
                n_t     = WIDTH'(1);
                n_z     = '0;
                n_state = msqrt_pkg::S_VERIFY;
            end
            msqrt_pkg::S_SEARCH: begin
                // least non-residue by euler's criterion
                if ((CW'(r_i) < CW'(r_p))
                        && (r_i < NW'(msqrt_pkg::NONRES_LIMIT))) begin
                    n_pacc  = WIDTH'(1);
                    n_pbase = WIDTH'(r_i);
                    n_pexp  = (r_p - 1'b1) >> 1;
                    n_pret  = msqrt_pkg::S_NRCHK;
                    n_state = msqrt_pkg::S_POW;
                end else begin
                    n_fail  = msqrt_pkg::STATUS_NOSQ;
                    n_low   = '0;
                    n_high  = '0;
                    n_state = msqrt_pkg::S_DONE;
                end
            end
            msqrt_pkg::S_NRCHK: begin
                if (r_pacc == r_p - 1'b1) begin
                    n_pacc  = WIDTH'(1);
                    n_pbase = WIDTH'(r_i);
                    n_pexp  = r_q;
                    n_pret  = msqrt_pkg::S_GOTZ;
                    n_state = msqrt_pkg::S_POW;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = msqrt_pkg::S_SEARCH;
                end
            end
            msqrt_pkg::S_GOTZ: begin
                n_z     = r_pacc;
                n_pacc  = WIDTH'(1);
                n_pbase = r_a;
                n_pexp  = (r_q >> 1) + 1'b1;
                n_pret  = msqrt_pkg::S_GOTR;
                n_state = msqrt_pkg::S_POW;
            end
            msqrt_pkg::S_GOTR: begin
                n_r     = r_pacc;
                n_pacc  = WIDTH'(1);
                n_pbase = r_a;
                n_pexp  = r_q;
                n_pret  = msqrt_pkg::S_GOTT;
                n_state = msqrt_pkg::S_POW;
            end
            msqrt_pkg::S_GOTT: begin
                n_t     = r_pacc;
                n_state = msqrt_pkg::S_LOOP;
            end
            msqrt_pkg::S_LOOP: begin
                if (r_t == WIDTH'(1)) begin
                    n_state = msqrt_pkg::S_VERIFY;
                end else begin
                    n_sq    = r_t;
                    n_found = SW'(1);
                    n_state = msqrt_pkg::S_FIND;
                end
            end
            msqrt_pkg::S_FIND: begin
                // least i with t^(2^i) = 1
                if (r_found < r_s) begin
                    n_mx     = r_sq;
                    n_my     = r_sq;
                    n_mstart = 1'b1;
                    n_ret    = msqrt_pkg::S_FINDW;
                    n_state  = msqrt_pkg::S_MWAIT;
                end else begin
                    n_fail  = msqrt_pkg::STATUS_NOSQ;
                    n_low   = '0;
                    n_high  = '0;
                    n_state = msqrt_pkg::S_DONE;
                end
            end
            msqrt_pkg::S_FINDW: begin
                n_sq = mul_prod;
                if (mul_prod == WIDTH'(1)) begin
                    n_b     = r_z;
                    n_k     = '0;
                    n_state = msqrt_pkg::S_BSQ;
                end else begin
                    n_found = r_found + 1'b1;
                    n_state = msqrt_pkg::S_FIND;
                end
            end
            msqrt_pkg::S_BSQ: begin
                n_mstart = 1'b1;
                n_state  = msqrt_pkg::S_MWAIT;
                if (bsq_need < (SW+1)'(r_s)) begin
                    n_mx  = r_b;
                    n_my  = r_b;
                    n_ret = msqrt_pkg::S_BSQW;
                end else begin
                    n_mx  = r_r;
                    n_my  = r_b;
                    n_ret = msqrt_pkg::S_UPR;
                end
            end
            msqrt_pkg::S_BSQW: begin
                n_b     = mul_prod;
                n_k     = r_k + 1'b1;
                n_state = msqrt_pkg::S_BSQ;
            end
            msqrt_pkg::S_UPR: begin
                n_r      = mul_prod;
                n_mx     = r_b;
                n_my     = r_b;
                n_mstart = 1'b1;
                n_ret    = msqrt_pkg::S_UPZ;
                n_state  = msqrt_pkg::S_MWAIT;
            end
            msqrt_pkg::S_UPZ: begin
                n_z      = mul_prod;
                n_mx     = r_t;
                n_my     = mul_prod;
                n_mstart = 1'b1;
                n_ret    = msqrt_pkg::S_UPT;
                n_state  = msqrt_pkg::S_MWAIT;
            end
            msqrt_pkg::S_UPT: begin
                n_t     = mul_prod;
                n_s     = r_found;
                n_state = msqrt_pkg::S_LOOP;
            end
            msqrt_pkg::S_VERIFY: begin
                n_mx     = r_r;
                n_my     = r_r;
                n_mstart = 1'b1;
                n_ret    = msqrt_pkg::S_CHECK;
                n_state  = msqrt_pkg::S_MWAIT;
            end
            msqrt_pkg::S_CHECK: begin
                // root must square back to the residue
                if (mul_prod == r_a) begin
                    n_low  = r_r;
                    n_high = r_p - r_r;
                    n_fail = msqrt_pkg::STATUS_OK;
                end else begin
                    n_low  = '0;
                    n_high = '0;
                    n_fail = msqrt_pkg::STATUS_NOSQ;
                end
                n_state = msqrt_pkg::S_DONE;
            end
            msqrt_pkg::S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_olow   = FW'(64'(r_low));
                    n_ohigh  = FW'(64'(r_high));
                    n_ostat  = r_fail;
                    n_state  = msqrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msqrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msqrt_pkg::S_IDLE;
            r_ret    <= msqrt_pkg::S_IDLE;
            r_pret   <= msqrt_pkg::S_IDLE;
            r_mstart <= 1'b0;
            r_rstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_pret   <= n_pret;
            r_mstart <= n_mstart;
            r_rstart <= n_rstart;
            r_ovalid <= n_ovalid;
        end
        r_p     <= n_p;
        r_a     <= n_a;
        r_q     <= n_q;
        r_r     <= n_r;
        r_t     <= n_t;
        r_z     <= n_z;
        r_b     <= n_b;
        r_sq    <= n_sq;
        r_s     <= n_s;
        r_found <= n_found;
        r_k     <= n_k;
        r_i     <= n_i;
        r_pacc  <= n_pacc;
        r_pbase <= n_pbase;
        r_pexp  <= n_pexp;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_low   <= n_low;
        r_high  <= n_high;
        r_fail  <= n_fail;
        r_olow  <= n_olow;
        r_ohigh <= n_ohigh;
        r_ostat <= n_ostat;
    end

    assign i_in.ready      = (r_state == msqrt_pkg::S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.root_low  = r_olow;
    assign o_out.root_high = r_ohigh;
    assign o_out.status    = r_ostat;
endmodule

>>> rtl/core/msqrt_check.sv
// port-level checker for modular_square_root, bound to the top level
// depends on msqrt_pkg for field widths and status codes
module msqrt_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [msqrt_pkg::FIELD_W-1:0] i_root_low,
    input logic [msqrt_pkg::FIELD_W-1:0] i_root_high,
    input logic                          i_status
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_root_low)
            && $stable(i_root_high) && $stable(i_status))
        else $error("stalled result changed");

    // a failed item carries zero roots
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == msqrt_pkg::STATUS_NOSQ) |->
            (i_root_low == '0) && (i_root_high == '0))
        else $error("non-square result with nonzero roots");

    // an accepted item keeps the sequencer busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind modular_square_root msqrt_check u_msqrt_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_root_low  (o_out.root_low),
    .i_root_high (o_out.root_high),
    .i_status    (o_out.status)
);

>>> verif/tb_top.sv
// self-checking testbench of the modular square root block
// depends on msqrt_pkg, msqrt_if and the modular_square_root rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [msqrt_pkg::FIELD_W-1:0] prime;
        logic [msqrt_pkg::FIELD_W-1:0] residue;
    } t_query;

    typedef struct packed {
        logic [msqrt_pkg::FIELD_W-1:0] root_low;
        logic [msqrt_pkg::FIELD_W-1:0] root_high;
        logic                          status;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    msqrt_in_if  in_ch ();
    msqrt_out_if out_ch ();

    modular_square_root DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // pending queries, expected roots, and error bookkeeping
    t_query pending_q[$];
    t_roots roots_q[$];
    int     n_errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     stim_done = 1'b0;

    // working values of the last item, as the block keeps them
    t_u64 odd_part, two_exponent, partial_root, error_term, nonresidue_power;

    // product fits in 64 bits since both operands are below 2^32
    function automatic t_u64 mulm(t_u64 x, t_u64 y, t_u64 m);
        return ((x % m) * (y % m)) % m;
    endfunction

    function automatic t_u64 powm(t_u64 b, t_u64 e, t_u64 m);
        t_u64 acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulm(acc, b, m);
            b = mulm(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic t_roots tonelli_shanks(t_query qy);
        t_roots res;
        t_u64 p, a, q, s, r, t, z, c, i, sq, found, b, hi;
        bit ok;
        p = qy.prime;
        a = qy.residue;
        ok = 1'b1;
        res = '{root_low: '0, root_high: '0, status: msqrt_pkg::STATUS_NOSQ};
        if (p < 2) return res;
        a = a % p;
        if (p == 2) begin
            res = '{root_low: a[31:0], root_high: a[31:0], status: msqrt_pkg::STATUS_OK};
            return res;
        end
        if (a == 0) begin
            res.status = msqrt_pkg::STATUS_OK;
            return res;
        end
        if (!p[0]) return res;
        q = p - 1;
        s = 0;
        while (!q[0]) begin
            q = q >> 1;
            s++;
        end
        odd_part = q;
        // euler's criterion rejects non-squares
        if (powm(a, (p - 1) >> 1, p) != 1) return res;
        if (s == 1) begin
            r = powm(a, (p >> 2) + 1, p);
            t = 1;
            z = 0;
        end else begin
            c = 0;
            for (i = 2; i < p && i < msqrt_pkg::NONRES_LIMIT; i++) begin
                if (powm(i, (p - 1) >> 1, p) == p - 1) begin
                    c = i;
                    break;
                end
            end
            if (c == 0) return res;
            z = powm(c, q, p);
            r = powm(a, (q >> 1) + 1, p);
            t = powm(a, q, p);
            while (ok && t != 1) begin
                sq = t;
                found = 0;
                for (i = 1; i < s; i++) begin
                    sq = mulm(sq, sq, p);
                    if (sq == 1) begin
                        found = i;
                        break;
                    end
                end
                if (found == 0) begin
                    ok = 1'b0;
                    break;
                end
                b = z;
                for (t_u64 k = 0; k + found + 1 < s; k++) b = mulm(b, b, p);
                r = mulm(r, b, p);
                z = mulm(b, b, p);
                t = mulm(t, z, p);
                s = found;
            end
        end
        two_exponent = s & 6'h3F;
        partial_root = r;
        error_term = t;
        nonresidue_power = z;
        if (!ok || mulm(r, r, p) != a) return res;
        hi = p - r;
        res.root_low = r[31:0];
        res.root_high = hi[31:0];
        res.status = msqrt_pkg::STATUS_OK;
        return res;
    endfunction

    function automatic bit is_prime(t_u64 n);
        if (n < 2) return 1'b0;
        if (n < 4) return 1'b1;
        if (!n[0]) return 1'b0;
        for (t_u64 d = 3; d * d <= n; d += 2)
            if (n % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    // random prime with p-1 divisible by 2^s exactly or more
    function automatic t_u64 prime_with_twos(int s);
        t_u64 p;
        do begin
            p = ((t_u64'($urandom_range(1, (32'h1 << (32 - s)) - 1))) << s) | 1;
        end while (!is_prime(p));
        return p;
    endfunction

    function automatic t_u64 prime_3mod4();
        t_u64 p;
        do begin
            p = t_u64'($urandom) | 3;
        end while (!is_prime(p));
        return p;
    endfunction

    function automatic t_u64 square_of_random(t_u64 p);
        t_u64 x;
        x = $urandom;
        return mulm(x, x, p);
    endfunction

    task automatic add_query(t_u64 p, t_u64 a);
        pending_q.push_back('{prime: p[31:0], residue: a[31:0]});
    endtask

    function automatic t_query random_query();
        t_u64 p, a;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind <= 5) begin
            p = prime_3mod4();
            a = square_of_random(p);
        end else if (kind <= 11) begin
            // deep reduction loop: primes with many factors of two in p-1
            p = prime_with_twos($urandom_range(2, 28));
            a = square_of_random(p);
        end else if (kind <= 13) begin
            p = ($urandom_range(0, 1)) ? prime_3mod4()
                                       : prime_with_twos($urandom_range(2, 12));
            a = $urandom % p;
        end else if (kind == 14) begin
            p = $urandom;
            a = $urandom;
        end else if (kind == 15) begin
            // small odd moduli, composites among them; keeps the candidate search short
            p = $urandom_range(9, 999) | 1;
            a = $urandom;
        end else if (kind == 16) begin
            p = 2;
            a = $urandom;
        end else if (kind == 17) begin
            p = prime_with_twos($urandom_range(2, 20));
            a = 0;
        end else if (kind == 18) begin
            // residue drawn from the full 32-bit range, mostly above the modulus
            p = $urandom_range(3, 65535);
            a = $urandom;
        end else begin
            p = ($urandom_range(0, 1)) ? t_u64'($urandom_range(0, 1))
                                       : t_u64'($urandom & ~32'h1);
            a = $urandom;
        end
        return '{prime: p[31:0], residue: a[31:0]};
    endfunction

    // driver: new item on the falling edge once the previous one was taken
    bit in_taken = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.prime <= '0;
            in_ch.residue <= '0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.prime <= pending_q[0].prime;
                in_ch.residue <= pending_q[0].residue;
                void'(pending_q.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.prime = '0;
        in_ch.residue = '0;
        out_ch.ready = 1'b0;
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        t_roots got, want;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken)
            roots_q.push_back(tonelli_shanks('{prime: in_ch.prime, residue: in_ch.residue}));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{root_low: out_ch.root_low, root_high: out_ch.root_high,
                    status: out_ch.status};
            if (roots_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result low=%h high=%h status=%b",
                             got.root_low, got.root_high, got.status);
            end else begin
                want = roots_q.pop_front();
                if (got != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp low=%h high=%h status=%b, ",
                                  "got low=%h high=%h status=%b"},
                                 want.root_low, want.root_high, want.status,
                                 got.root_low, got.root_high, got.status);
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0 || in_ch.valid || roots_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_u64 p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: degenerate moduli, both short paths, deep loops, composites
        add_query(0, 5);
        add_query(1, 32'hFFFF_FFFF);
        add_query(2, 0);
        add_query(2, 1);
        add_query(2, 32'hFFFF_FFFF);
        add_query(4, 1);
        add_query(3, 1);
        add_query(7, 2);
        add_query(7, 3);
        add_query(13, 10);
        add_query(17, 32'h0000_0008);
        add_query(65537, 32'hFFFF_FFFF);
        add_query(32'hFFFF_FFFB, 0);
        add_query(32'hFFFF_FFFB, 32'hFFFF_FFFF);
        add_query(32'hFFFF_FFFB, 4);
        add_query(32'hC000_0001, 9);
        add_query(32'hC000_0001, 32'h1234_5678);
        add_query(32'hFFFF_FFFF, 1);
        add_query(32'hFFFF_FFFE, 1);
        add_query(9, 7);
        add_query(15, 4);
        add_query(21, 1);
        add_query(25, 1);
        p = prime_with_twos(20);
        add_query(p, square_of_random(p));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int n = 0; n < 32; n++) begin
                pending_q.push_back(random_query());
                // let the block run ahead between some items
                if ($urandom_range(0, 7) == 0) @(posedge i_clk);
            end
            // sender holds off until every result is back
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        stim_done = 1'b1;
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && roots_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog far above the slowest legal run
    initial begin
        #400_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> modular_square_root.f
rtl/core/msqrt_pkg.sv
rtl/core/msqrt_if.sv
rtl/core/msqrt_mulmod.sv
rtl/core/msqrt_reduce.sv
rtl/core/modular_square_root.sv
rtl/core/msqrt_check.sv
verif/tb_top.sv
